>>> src/rled_pkg.sv
// Shared types and constants for the RLE image to RGB565 decoder.
// No dependencies.
package rled_pkg;

  localparam logic [31:0] ImgMagic  = 32'h5245_4900;
  localparam logic [7:0]  CompMask  = 8'h0F;
  localparam logic [7:0]  CtrlNop   = 8'h80;
  localparam logic [3:0]  HdrLast   = 4'd11;
  localparam logic [7:0]  DepthMono = 8'd1;
  localparam logic [7:0]  DepthRgb  = 8'd3;
  localparam logic [7:0]  DepthRgba = 8'd4;
  localparam logic [3:0]  CompRaw   = 4'd0;
  localparam logic [3:0]  CompRle   = 4'd1;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StShortHdr  = 3'd1;
  localparam logic [2:0] StBadSize   = 3'd2;
  localparam logic [2:0] StBadDepth  = 3'd3;
  localparam logic [2:0] StBadComp   = 3'd4;
  localparam logic [2:0] StFewData   = 3'd5;
  localparam logic [2:0] StRunOvf    = 3'd6;

  localparam logic ItemPixel  = 1'b0;
  localparam logic ItemStatus = 1'b1;

  typedef struct packed {
    logic        item_type;
    logic [15:0] pixel_value;
    logic [7:0]  repeat_count;
    logic [2:0]  status_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_of_step;
  } result_t;

  // Results caused by one accepted byte, in order.
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } step_t;

endpackage

>>> src/rled_core.sv
// Header parser, raw/PackBits body decoder and RGB565 conversion.
// Depends on rled_pkg.
module rled_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_file_i,
  output rled_pkg::step_t step_o
);

  localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_BITS) - 64'd1);

  typedef enum logic [2:0] {
    PhHeader, PhRaw, PhRle, PhDone, PhError
  } phase_e;

  typedef enum logic [1:0] {
    RmControl, RmLiteral, RmReplicate
  } run_mode_e;

  phase_e                  phase_q, phase_d;
  run_mode_e               run_mode_q, run_mode_d;
  logic [3:0]              hdr_idx_q, hdr_idx_d;
  logic [31:0]             magic_q, magic_d;
  logic [15:0]             width_q, width_d;
  logic [15:0]             height_q, height_d;
  logic [7:0]              depth_q, depth_d;
  logic [3:0]              comp_q, comp_d;
  logic [COUNT_BITS-1:0]   pix_left_q, pix_left_d;
  logic [23:0]             held_q, held_d;
  logic [1:0]              bip_q, bip_d;
  logic [7:0]              run_left_q, run_left_d;
  logic [2:0]              err_q, err_d;

  logic [31:0]             pixel_count;
  logic                    count_ovf;
  logic [23:0]             held_base, held_new;
  logic                    px_done;
  logic [1:0]              bip_next;
  logic [7:0]              r_ch, g_ch, b_ch;
  logic [15:0]             px;
  logic [8:0]              ctrl_cnt;
  logic                    pix_valid;
  logic [7:0]              pix_rep;
  logic [2:0]              status;
  rled_pkg::result_t       pix_res, stat_res;

  assign pixel_count = 32'(width_q) * 32'(height_q);
  assign count_ovf   = |(pixel_count & ~CountMask);
  assign ctrl_cnt    = (data_byte_i < rled_pkg::CtrlNop) ? 9'(data_byte_i) + 9'd1
                                                         : 9'd257 - 9'(data_byte_i);

  // Pixel assembly from body bytes.
  always_comb begin
    held_base = (bip_q == 2'd0) ? 24'd0 : held_q;
    held_new  = held_base;
    case (bip_q)
      2'd0:    held_new[7:0]   = data_byte_i;
      2'd1:    held_new[15:8]  = data_byte_i;
      2'd2:    held_new[23:16] = data_byte_i;
      default: held_new        = held_base;
    endcase
    px_done  = !((8'(bip_q) + 8'd1) < depth_q);
    bip_next = px_done ? 2'd0 : bip_q + 2'd1;
    r_ch     = held_new[7:0];
    g_ch     = (depth_q == rled_pkg::DepthMono) ? r_ch : held_new[15:8];
    b_ch     = (depth_q == rled_pkg::DepthMono) ? r_ch : held_new[23:16];
    px       = {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
  end

  always_comb begin
    phase_d    = phase_q;
    run_mode_d = run_mode_q;
    hdr_idx_d  = hdr_idx_q;
    magic_d    = magic_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    comp_d     = comp_q;
    pix_left_d = pix_left_q;
    held_d     = held_q;
    bip_d      = bip_q;
    run_left_d = run_left_q;
    err_d      = err_q;
    pix_valid  = 1'b0;
    pix_rep    = 8'd0;
    status     = rled_pkg::StOk;

    case (phase_q)
      PhHeader: begin
        if (hdr_idx_q < 4'd4) begin
          magic_d = magic_q | (32'(data_byte_i) << {hdr_idx_q[1:0], 3'b000});
        end else if (hdr_idx_q < 4'd6) begin
          width_d = width_q | (16'(data_byte_i) << {hdr_idx_q[0], 3'b000});
        end else if (hdr_idx_q < 4'd8) begin
          height_d = height_q | (16'(data_byte_i) << {hdr_idx_q[0], 3'b000});
        end else if (hdr_idx_q == 4'd8) begin
          depth_d = data_byte_i;
        end else if (hdr_idx_q == 4'd9) begin
          comp_d = data_byte_i[3:0] & rled_pkg::CompMask[3:0];
        end
        hdr_idx_d = hdr_idx_q + 4'd1;
        if (hdr_idx_q == rled_pkg::HdrLast) begin
          if (magic_q != rled_pkg::ImgMagic || width_q == 16'd0 || height_q == 16'd0
              || count_ovf) begin
            phase_d = PhError;
            err_d   = rled_pkg::StBadSize;
          end else if (depth_q != rled_pkg::DepthMono && depth_q != rled_pkg::DepthRgb
                       && depth_q != rled_pkg::DepthRgba) begin
            phase_d = PhError;
            err_d   = rled_pkg::StBadDepth;
          end else if (comp_q > rled_pkg::CompRle) begin
            phase_d = PhError;
            err_d   = rled_pkg::StBadComp;
          end else begin
            pix_left_d = pixel_count[COUNT_BITS-1:0];
            bip_d      = 2'd0;
            run_mode_d = RmControl;
            run_left_d = 8'd0;
            phase_d    = (comp_q == rled_pkg::CompRle) ? PhRle : PhRaw;
          end
        end
      end
      PhRaw: begin
        held_d = held_new;
        bip_d  = bip_next;
        if (px_done) begin
          pix_valid  = 1'b1;
          pix_rep    = 8'd1;
          pix_left_d = pix_left_q - COUNT_BITS'(1);
          if (pix_left_d == '0) begin
            phase_d = PhDone;
          end
        end
      end
      PhRle: begin
        if (run_mode_q == RmControl) begin
          if (data_byte_i != rled_pkg::CtrlNop) begin
            if (COUNT_BITS'(ctrl_cnt) > pix_left_q) begin
              phase_d = PhError;
              err_d   = rled_pkg::StRunOvf;
            end else begin
              run_left_d = ctrl_cnt[7:0];
              run_mode_d = (data_byte_i < rled_pkg::CtrlNop) ? RmLiteral : RmReplicate;
              bip_d      = 2'd0;
            end
          end
        end else begin
          held_d = held_new;
          bip_d  = bip_next;
          if (px_done) begin
            pix_valid = 1'b1;
            if (run_mode_q == RmLiteral) begin
              pix_rep    = 8'd1;
              pix_left_d = pix_left_q - COUNT_BITS'(1);
              run_left_d = run_left_q - 8'd1;
              if (run_left_d == 8'd0) begin
                run_mode_d = RmControl;
              end
            end else begin
              pix_rep    = run_left_q;
              pix_left_d = pix_left_q - COUNT_BITS'(run_left_q);
              run_left_d = 8'd0;
              run_mode_d = RmControl;
            end
            if (pix_left_d == '0) begin
              phase_d = PhDone;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (phase_d == PhError) begin
      status = err_d;
    end else if (phase_d == PhHeader) begin
      status = rled_pkg::StShortHdr;
    end else if (phase_d == PhDone) begin
      status = rled_pkg::StOk;
    end else begin
      status = rled_pkg::StFewData;
    end

    pix_res              = '0;
    pix_res.item_type    = rled_pkg::ItemPixel;
    pix_res.pixel_value  = px;
    pix_res.repeat_count = pix_rep;
    pix_res.last_of_step = !end_of_file_i;

    stat_res              = '0;
    stat_res.item_type    = rled_pkg::ItemStatus;
    stat_res.status_code  = status;
    stat_res.image_width  = width_d;
    stat_res.image_height = height_d;
    stat_res.last_of_step = 1'b1;

    step_o.first_valid  = accept_i && (pix_valid || end_of_file_i);
    step_o.second_valid = accept_i && pix_valid && end_of_file_i;
    step_o.first        = pix_valid ? pix_res : stat_res;
    step_o.second       = stat_res;

    if (end_of_file_i) begin
      phase_d    = PhHeader;
      run_mode_d = RmControl;
      hdr_idx_d  = 4'd0;
      magic_d    = 32'd0;
      width_d    = 16'd0;
      height_d   = 16'd0;
      depth_d    = 8'd0;
      comp_d     = 4'd0;
      pix_left_d = '0;
      held_d     = 24'd0;
      bip_d      = 2'd0;
      run_left_d = 8'd0;
      err_d      = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      run_mode_q <= RmControl;
      hdr_idx_q  <= 4'd0;
      magic_q    <= 32'd0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      depth_q    <= 8'd0;
      comp_q     <= 4'd0;
      pix_left_q <= '0;
      held_q     <= 24'd0;
      bip_q      <= 2'd0;
      run_left_q <= 8'd0;
      err_q      <= 3'd0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      run_mode_q <= run_mode_d;
      hdr_idx_q  <= hdr_idx_d;
      magic_q    <= magic_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      comp_q     <= comp_d;
      pix_left_q <= pix_left_d;
      held_q     <= held_d;
      bip_q      <= bip_d;
      run_left_q <= run_left_d;
      err_q      <= err_d;
    end
  end

endmodule

>>> src/rled_res_fifo.sv
// Four-entry result queue; takes up to two results per cycle, gives one per cycle while the reader is ready.
// Depends on rled_pkg.
module rled_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rled_pkg::step_t   step_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rled_pkg::result_t out_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  rled_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              pop;
  logic [PtrW:0]     push_n;

  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = (PtrW + 1)'(step_i.first_valid) + (PtrW + 1)'(step_i.second_valid);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign space_o     = (cnt_q <= (PtrW + 1)'(Depth - 2));
  assign wr_ptr_d    = wr_ptr_q + push_n[PtrW-1:0];
  assign rd_ptr_d    = rd_ptr_q + PtrW'(pop);
  assign cnt_d       = cnt_q + push_n - (PtrW + 1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.first_valid) begin
      mem_q[wr_ptr_q] <= step_i.first;
    end
    if (step_i.second_valid) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= step_i.second;
    end
  end

endmodule

>>> src/rle_image_to_rgb565_decoder_unit.sv
// Top level of the RLE image to RGB565 decoder.
// Depends on rled_pkg, rled_core and rled_res_fifo.
//
// Takes an image file one byte per transaction and accepts one byte every
// cycle while input ready is high: each byte updates the parser state and
// drops its results (none, one pixel run, and on the final byte a status)
// into a four-entry result queue. Input ready falls only while that queue
// holds more than two results, e.g. while the output side is stalled. A
// byte's results are registered in that queue before they reach the output.
// No clearing pass is needed after reset; the block is ready at once.
module rle_image_to_rgb565_decoder_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_type_o,
  output logic [15:0] pixel_value_o,
  output logic [7:0]  repeat_count_o,
  output logic [2:0]  status_code_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        last_of_step_o
);

  logic              accept;
  rled_pkg::step_t   step;
  rled_pkg::result_t res;

  assign accept = in_valid_i && in_ready_o;

  rled_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .step_o        (step)
  );

  rled_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res)
  );

  assign item_type_o    = res.item_type;
  assign pixel_value_o  = res.pixel_value;
  assign repeat_count_o = res.repeat_count;
  assign status_code_o  = res.status_code;
  assign image_width_o  = res.image_width;
  assign image_height_o = res.image_height;
  assign last_of_step_o = res.last_of_step;

endmodule

>>> src/rled_checker.sv
// Port-level checks for the RLE image decoder, bound to the top level.
// Depends on rle_image_to_rgb565_decoder_unit and rled_pkg.
module rled_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        end_of_file_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        item_type_o,
  input logic [15:0] pixel_value_o,
  input logic [7:0]  repeat_count_o,
  input logic [2:0]  status_code_o,
  input logic [15:0] image_width_o,
  input logic [15:0] image_height_o,
  input logic        last_of_step_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(item_type_o) && $stable(repeat_count_o) && $stable(status_code_o))
    else $error("result changed while stalled");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_type_o == rled_pkg::ItemStatus |->
      pixel_value_o == 16'd0 && repeat_count_o == 8'd0 && last_of_step_o)
    else $error("malformed status transaction");

  a_pixel_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_type_o == rled_pkg::ItemPixel |->
      repeat_count_o != 8'd0 && repeat_count_o <= 8'd128
      && status_code_o == rled_pkg::StOk && image_width_o == 16'd0
      && image_height_o == 16'd0)
    else $error("malformed pixel transaction");

  a_eof_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_file_i |=> out_valid_o)
    else $error("final byte produced no result");

endmodule

bind rle_image_to_rgb565_decoder_unit rled_checker u_rled_checker (.*);
